// ===== rtl/qvr_pkg.sv =====
// Shared types, widths and status codes of the quaternion vector rotation core.
// Used by every module under rtl.
package qvr_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned N_W    = 63;
    localparam int unsigned E_W    = 64;
    localparam int unsigned ACC_W  = 98;
    localparam int unsigned REM_W  = 98;
    localparam int unsigned QUO_W  = 32;
    localparam int unsigned D_W    = N_W + 1;

    localparam logic signed [DATA_W-1:0] Q_LIMIT = 32'sd1073741824;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

endpackage

// ===== rtl/quaternion_vector_rotate_core.sv =====
// Top level of the quaternion vector rotation core: front end, matrix-vector
// stage, divider and the saturating output register. Uses qvr_pkg.
//
// Rotates a Q16.16 vector by a Q16.16 quaternion that need not be normalized,
// body to world (action 0) or world to body (action 1). The core takes one item
// every clock cycle and busy stays low; the result strobe o_valid rises for each
// accepted item, in the order of acceptance. A restoring divider forms the
// rounded quotient for each component. A quaternion of zero norm returns a
// zero vector with status 1; a saturated component returns status 2.
module quaternion_vector_rotate_core
    import qvr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic         i_action,
    input  t_data        i_quat_w,
    input  t_data        i_quat_x,
    input  t_data        i_quat_y,
    input  t_data        i_quat_z,
    input  t_data        i_vec_x,
    input  t_data        i_vec_y,
    input  t_data        i_vec_z,
    output logic         o_valid,
    output t_data        o_rot_x,
    output t_data        o_rot_y,
    output t_data        o_rot_z,
    output logic [1:0]   o_status
);

    t_data in_q [0:3];
    t_data in_v [0:2];

    t_ctl                  qm_ctl;
    logic signed [E_W-1:0] qm_m [0:8];
    logic [N_W-1:0]        qm_n;
    t_data                 qm_v [0:2];

    t_ctl              mv_ctl;
    logic [N_W-1:0]    mv_n;
    logic              mv_neg [0:2];
    logic [REM_W-1:0]  mv_dvd [0:2];

    t_ctl              dv_ctl;
    logic              dv_neg [0:2];
    logic              dv_big [0:2];
    logic [QUO_W-1:0]  dv_quo [0:2];

    logic       r_valid;
    t_data      r_rot [0:2];
    logic [1:0] r_status;

    t_data      n_rot [0:2];
    logic [1:0] n_status;
    logic       sat [0:2];

    assign busy = 1'b0;

    assign in_q[0] = i_quat_w;
    assign in_q[1] = i_quat_x;
    assign in_q[2] = i_quat_y;
    assign in_q[3] = i_quat_z;
    assign in_v[0] = i_vec_x;
    assign in_v[1] = i_vec_y;
    assign in_v[2] = i_vec_z;

    qvr_quat_mat u_quat_mat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start & ~busy),
        .i_action (i_action),
        .i_q      (in_q),
        .i_v      (in_v),
        .o_ctl    (qm_ctl),
        .o_m      (qm_m),
        .o_n      (qm_n),
        .o_v      (qm_v)
    );

    qvr_mat_vec u_mat_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (qm_ctl),
        .i_m     (qm_m),
        .i_n     (qm_n),
        .i_v     (qm_v),
        .o_ctl   (mv_ctl),
        .o_n     (mv_n),
        .o_neg   (mv_neg),
        .o_dvd   (mv_dvd)
    );

    qvr_round_div u_round_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mv_ctl),
        .i_n     (mv_n),
        .i_neg   (mv_neg),
        .i_dvd   (mv_dvd),
        .o_ctl   (dv_ctl),
        .o_neg   (dv_neg),
        .o_big   (dv_big),
        .o_quo   (dv_quo)
    );

    // Clamp, apply sign, and drop everything for a zero-norm quaternion
    always_comb begin
        n_status = ST_OK;
        for (int l = 0; l < 3; l++) begin
            sat[l] = dv_big[l] | (dv_neg[l] ? (dv_quo[l] > 32'h8000_0000)
                                             : dv_quo[l][QUO_W-1]);
            if (sat[l]) begin
                n_rot[l] = dv_neg[l] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                n_status = ST_SAT;
            end else begin
                n_rot[l] = dv_neg[l] ? -$signed(dv_quo[l]) : $signed(dv_quo[l]);
            end
        end
        if (dv_ctl.zero) begin
            for (int l = 0; l < 3; l++) n_rot[l] = '0;
            n_status = ST_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= dv_ctl.valid;
        end
        r_rot    <= n_rot;
        r_status <= n_status;
    end

    assign o_valid  = r_valid;
    assign o_rot_x  = r_rot[0];
    assign o_rot_y  = r_rot[1];
    assign o_rot_z  = r_rot[2];
    assign o_status = r_status;

`ifndef SYNTHESIS
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ZERO |-> o_rot_x == 0 && o_rot_y == 0 && o_rot_z == 0)
        else $error("zero-norm item with nonzero vector");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_ZERO || o_status == ST_SAT)
        else $error("undefined status code");

    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_SAT |->
            o_rot_x == 32'sh7FFF_FFFF || o_rot_x == 32'sh8000_0000 ||
            o_rot_y == 32'sh7FFF_FFFF || o_rot_y == 32'sh8000_0000 ||
            o_rot_z == 32'sh7FFF_FFFF || o_rot_z == 32'sh8000_0000)
        else $error("saturation status without a clamped component");

    a_div_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv_ctl.valid |-> ##(QUO_W + 2) o_valid)
        else $error("item lost in the divider");
`endif

endmodule

// ===== rtl/qvr_quat_mat.sv =====
// Quaternion front end: range halving, component products and rotation matrix.
// Three register stages; depends on qvr_pkg.
module qvr_quat_mat
    import qvr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_action,
    input  t_data             i_q [0:3],
    input  t_data             i_v [0:2],
    output t_ctl              o_ctl,
    output logic signed [E_W-1:0] o_m [0:8],
    output logic [N_W-1:0]    o_n,
    output t_data             o_v [0:2]
);

    logic  r1_valid, r2_valid, r3_valid;
    logic  r1_act, r2_act;
    t_data r1_q [0:3];
    t_data r1_v [0:2];
    t_data r2_v [0:2];
    t_data r3_v [0:2];
    logic signed [PROD_W-1:0] r2_p [0:9];
    logic signed [E_W-1:0]    r3_m [0:8];
    logic [N_W-1:0]           r3_n;
    logic                     r3_zero;

    logic  big;
    t_data n_q [0:3];
    logic signed [E_W-1:0] n_e [0:8];
    logic signed [PROD_W-1:0] n_sum;

    // Halve all four when any one is out of range, so that the norm fits
    always_comb begin
        big = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (i_q[i] > Q_LIMIT || i_q[i] < -Q_LIMIT) big = 1'b1;
        end
        for (int i = 0; i < 4; i++) begin
            n_q[i] = big ? (i_q[i] >>> 1) : i_q[i];
        end
    end

    // products: ww xx yy zz xy wz xz wy yz wx
    always_comb begin
        n_sum = r2_p[0] + r2_p[1] + r2_p[2] + r2_p[3];
        n_e[0] = r2_p[0] + r2_p[1] - r2_p[2] - r2_p[3];
        n_e[1] = (r2_p[4] - r2_p[5]) <<< 1;
        n_e[2] = (r2_p[6] + r2_p[7]) <<< 1;
        n_e[3] = (r2_p[4] + r2_p[5]) <<< 1;
        n_e[4] = r2_p[0] - r2_p[1] + r2_p[2] - r2_p[3];
        n_e[5] = (r2_p[8] - r2_p[9]) <<< 1;
        n_e[6] = (r2_p[6] - r2_p[7]) <<< 1;
        n_e[7] = (r2_p[8] + r2_p[9]) <<< 1;
        n_e[8] = r2_p[0] - r2_p[1] - r2_p[2] + r2_p[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
        r1_act <= i_action;
        r2_act <= r1_act;
        for (int i = 0; i < 4; i++) r1_q[i] <= n_q[i];
        for (int i = 0; i < 3; i++) begin
            r1_v[i] <= i_v[i];
            r2_v[i] <= r1_v[i];
            r3_v[i] <= r2_v[i];
        end
        r2_p[0] <= r1_q[0] * r1_q[0];
        r2_p[1] <= r1_q[1] * r1_q[1];
        r2_p[2] <= r1_q[2] * r1_q[2];
        r2_p[3] <= r1_q[3] * r1_q[3];
        r2_p[4] <= r1_q[1] * r1_q[2];
        r2_p[5] <= r1_q[0] * r1_q[3];
        r2_p[6] <= r1_q[1] * r1_q[3];
        r2_p[7] <= r1_q[0] * r1_q[2];
        r2_p[8] <= r1_q[2] * r1_q[3];
        r2_p[9] <= r1_q[0] * r1_q[1];
        // transpose for world to body
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r3_m[i*3+j] <= r2_act ? n_e[j*3+i] : n_e[i*3+j];
            end
        end
        r3_n    <= n_sum[N_W-1:0];
        r3_zero <= (n_sum == '0);
    end

    assign o_ctl.valid = r3_valid;
    assign o_ctl.zero  = r3_zero;
    assign o_m = r3_m;
    assign o_n = r3_n;
    assign o_v = r3_v;

endmodule

// ===== rtl/qvr_mat_vec.sv =====
// Matrix times vector with split partial products, then the rounded dividend
// magnitude 2|acc| + n for each component. Four register stages; uses qvr_pkg.
module qvr_mat_vec
    import qvr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic signed [E_W-1:0] i_m [0:8],
    input  logic [N_W-1:0]    i_n,
    input  t_data             i_v [0:2],
    output t_ctl              o_ctl,
    output logic [N_W-1:0]    o_n,
    output logic              o_neg [0:2],
    output logic [REM_W-1:0]  o_dvd [0:2]
);

    logic r4_valid, r5_valid, r6_valid, r7_valid;
    logic r4_zero, r5_zero, r6_zero, r7_zero;
    logic [N_W-1:0] r4_n, r5_n, r6_n, r7_n;
    logic signed [DATA_W*2:0]   r4_plo [0:8];
    logic signed [DATA_W*2-1:0] r4_phi [0:8];
    logic signed [ACC_W-1:0]    r5_t [0:8];
    logic signed [ACC_W-1:0]    r6_acc [0:2];
    logic                       r7_neg [0:2];
    logic [REM_W-1:0]           r7_dvd [0:2];

    logic signed [ACC_W-1:0] acc2 [0:2];
    logic [REM_W-1:0]        n_ext;

    always_comb begin
        n_ext = REM_W'(r6_n);
        for (int i = 0; i < 3; i++) acc2[i] = r6_acc[i] <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else begin
            r4_valid <= i_ctl.valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
        end
        r4_zero <= i_ctl.zero;
        r5_zero <= r4_zero;
        r6_zero <= r5_zero;
        r7_zero <= r6_zero;
        r4_n <= i_n;
        r5_n <= r4_n;
        r6_n <= r5_n;
        r7_n <= r6_n;
        // split each entry into an unsigned low word and a signed high word
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r4_plo[i*3+j] <= $signed({1'b0, i_m[i*3+j][DATA_W-1:0]}) * i_v[j];
                r4_phi[i*3+j] <= $signed(i_m[i*3+j][E_W-1:DATA_W]) * i_v[j];
            end
        end
        for (int k = 0; k < 9; k++) begin
            r5_t[k] <= (ACC_W'(r4_phi[k]) <<< DATA_W) + ACC_W'(r4_plo[k]);
        end
        for (int i = 0; i < 3; i++) begin
            r6_acc[i] <= r5_t[i*3] + r5_t[i*3+1] + r5_t[i*3+2];
            r7_neg[i] <= r6_acc[i][ACC_W-1];
            r7_dvd[i] <= r6_acc[i][ACC_W-1] ? (n_ext - $unsigned(acc2[i]))
                                             : ($unsigned(acc2[i]) + n_ext);
        end
    end

    assign o_ctl.valid = r7_valid;
    assign o_ctl.zero  = r7_zero;
    assign o_n   = r7_n;
    assign o_neg = r7_neg;
    assign o_dvd = r7_dvd;

endmodule

// ===== rtl/qvr_round_div.sv =====
// Pipelined restoring divider, three lanes, one quotient bit per stage, plus
// an up-front check for quotients of 2^32 and above. Uses qvr_pkg.
module qvr_round_div
    import qvr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic [N_W-1:0]    i_n,
    input  logic              i_neg [0:2],
    input  logic [REM_W-1:0]  i_dvd [0:2],
    output t_ctl              o_ctl,
    output logic              o_neg [0:2],
    output logic              o_big [0:2],
    output logic [QUO_W-1:0]  o_quo [0:2]
);

    logic             r_valid [0:QUO_W];
    logic             r_zero  [0:QUO_W];
    logic [D_W-1:0]   r_d     [0:QUO_W];
    logic             r_neg   [0:QUO_W][0:2];
    logic             r_big   [0:QUO_W][0:2];
    logic [REM_W-1:0] r_rem   [0:QUO_W][0:2];
    logic [QUO_W-1:0] r_quo   [0:QUO_W][0:2];

    logic [REM_W-1:0] n_rem [0:QUO_W-1][0:2];
    logic [QUO_W-1:0] n_quo [0:QUO_W-1][0:2];
    logic [REM_W-1:0] sh    [0:QUO_W-1];
    logic [D_W-1:0]   d0;
    logic [REM_W-1:0] dtop;

    always_comb begin
        d0   = {i_n, 1'b0};
        dtop = REM_W'(d0) << QUO_W;
        for (int k = 0; k < QUO_W; k++) begin
            sh[k] = REM_W'(r_d[k]) << (QUO_W - 1 - k);
            for (int l = 0; l < 3; l++) begin
                n_rem[k][l] = r_rem[k][l];
                n_quo[k][l] = r_quo[k][l];
                if (r_rem[k][l] >= sh[k]) begin
                    n_rem[k][l] = r_rem[k][l] - sh[k];
                    n_quo[k][l][QUO_W-1-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QUO_W; k++) r_valid[k] <= 1'b0;
        end else begin
            r_valid[0] <= i_ctl.valid;
            for (int k = 0; k < QUO_W; k++) r_valid[k+1] <= r_valid[k];
        end
        r_zero[0] <= i_ctl.zero;
        r_d[0]    <= d0;
        for (int l = 0; l < 3; l++) begin
            r_neg[0][l] <= i_neg[l];
            r_big[0][l] <= (i_dvd[l] >= dtop);
            r_rem[0][l] <= i_dvd[l];
            r_quo[0][l] <= '0;
        end
        for (int k = 0; k < QUO_W; k++) begin
            r_zero[k+1] <= r_zero[k];
            r_d[k+1]    <= r_d[k];
            for (int l = 0; l < 3; l++) begin
                r_neg[k+1][l] <= r_neg[k][l];
                r_big[k+1][l] <= r_big[k][l];
                r_rem[k+1][l] <= n_rem[k][l];
                r_quo[k+1][l] <= n_quo[k][l];
            end
        end
    end

    assign o_ctl.valid = r_valid[QUO_W];
    assign o_ctl.zero  = r_zero[QUO_W];
    assign o_neg = r_neg[QUO_W];
    assign o_big = r_big[QUO_W];
    assign o_quo = r_quo[QUO_W];

endmodule
